@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the debouncer modules.
// Each check is sampled on the rising clock edge and is muted while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define SCPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define SCPD_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/scpd_pkg.sv @@
package scpd_pkg;

  // Field widths fixed by the interface.
  localparam int SLOT_W  = 3;
  localparam int CARD_W  = 8;
  localparam int CFG_W   = 4;
  localparam int CNT_W   = 4;

  // Counter limit before saturation.
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  // Configuration register indexes and reset values.
  localparam logic CFG_IDX_PRESET  = 1'b0;
  localparam logic CFG_IDX_CONFIRM = 1'b1;
  localparam logic [CFG_W-1:0] PRESET_RESET  = 4'd4;
  localparam logic [CFG_W-1:0] CONFIRM_RESET = 4'd7;

  // Depth of the queue between classifier and slot engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Per-slot phase.
  typedef enum logic [1:0] {
    PH_EMPTY       = 2'd0,
    PH_WAIT_INSERT = 2'd1,
    PH_WORKING     = 2'd2,
    PH_WAIT_REMOVE = 2'd3
  } phase_t;

  // Event reported with a result.
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_INSERTED = 2'd1,
    EV_REFUSED  = 2'd2,
    EV_REMOVED  = 2'd3
  } event_t;

  // Live configuration.
  typedef struct packed {
    logic [CFG_W-1:0] count_preset;
    logic [CFG_W-1:0] confirm_level;
  } cfg_t;

  // Classified poll request handed from the front to the back.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              in_range;
    logic [CARD_W-1:0] cid;
    logic              insert_ok;
    logic              end_of_sweep;
  } req_t;

endpackage

@@ rtl/scpd_front.sv @@
module scpd_front #(
  parameter int SLOT_COUNT = 7,
  parameter int TYPE_BITS  = 8
) (
  input  logic [scpd_pkg::SLOT_W-1:0] slot_index,
  input  logic [scpd_pkg::CARD_W-1:0] card_type,
  input  logic                        insert_ok,
  input  logic                        end_of_sweep,
  output scpd_pkg::req_t              req
);
  import scpd_pkg::*;

  localparam logic [15:0] TYPE_MASK = 16'((32'd1 << TYPE_BITS) - 32'd1);

  logic [15:0] cid_wide;

  // Trim the card type to the stored type width and flag slots that exist.
  always_comb begin
    cid_wide         = {8'b0, card_type} & TYPE_MASK;
    req.slot         = slot_index;
    req.in_range     = (32'(slot_index) < SLOT_COUNT);
    req.cid          = cid_wide[CARD_W-1:0];
    req.insert_ok    = insert_ok;
    req.end_of_sweep = end_of_sweep;
  end

endmodule

@@ rtl/scpd_queue.sv @@
`include "assert_macros.svh"

module scpd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scpd_pkg::req_t push_req,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output scpd_pkg::req_t pop_req
);
  import scpd_pkg::*;

  req_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_req = mem[rd_ptr];

  // Request storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_req;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SCPD_NEVER(a_no_overfill, count > QCNT_W'(QUEUE_DEPTH), "queue fill level above depth")
  `SCPD_NEVER(a_no_pop_empty, pop && empty, "request taken from an empty queue")
  `SCPD_NEVER(a_no_push_full, push && full && !pop, "request written into a full queue")

endmodule

@@ rtl/scpd_back.sv @@
`include "assert_macros.svh"

module scpd_back #(
  parameter int SLOT_COUNT = 7,
  parameter int TYPE_BITS  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  scpd_pkg::cfg_t              cfg,
  input  logic                        req_avail,
  input  scpd_pkg::req_t              req,
  output logic                        req_take,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [scpd_pkg::SLOT_W-1:0] slot_id,
  output logic [1:0]                  slot_status,
  output logic [1:0]                  event_code,
  output logic [scpd_pkg::CARD_W-1:0] held_type,
  output logic                        all_settled
);
  import scpd_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Per-slot state.
  phase_t                 phase [SLOT_COUNT];
  logic [CNT_W-1:0]       count [SLOT_COUNT];
  logic [TYPE_BITS-1:0]   inst  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  seen;
  logic                   announced;

  logic [IDX_W-1:0]       idx;
  phase_t                 ph;
  logic [CNT_W-1:0]       cnt;
  logic [15:0]            inst_wide;
  logic [CARD_W-1:0]      inst8;
  logic [15:0]            cid_wide;
  logic [CNT_W:0]         up_val;
  logic                   up_commit;
  logic [CNT_W-1:0]       up_sat;
  logic                   down_abandon;
  logic [CNT_W-1:0]       down_val;
  phase_t                 ph_next;
  logic [CNT_W-1:0]       cnt_next;
  logic [TYPE_BITS-1:0]   inst_next;
  logic                   seen_set;
  event_t                 ev;
  logic [SLOT_COUNT-1:0]  seen_next;
  logic                   pulse;
  logic [15:0]            held_wide;

  assign req_take = req_avail && (!out_valid || !out_stall);

  // Read the polled slot and work out its update.
  always_comb begin
    idx          = IDX_W'(req.slot);
    ph           = phase[idx];
    cnt          = count[idx];
    inst_wide    = 16'(inst[idx]);
    inst8        = inst_wide[CARD_W-1:0];
    cid_wide     = {8'b0, req.cid};
    up_val       = {1'b0, cnt} + 1'b1;
    up_commit    = up_val > {1'b0, cfg.confirm_level};
    up_sat       = up_val[CNT_W] ? CNT_MAX : up_val[CNT_W-1:0];
    down_abandon = (cnt <= 4'd1);
    down_val     = (cnt == '0) ? '0 : cnt - 1'b1;
    ph_next      = ph;
    cnt_next     = cnt;
    inst_next    = inst[idx];
    seen_set     = 1'b0;
    ev           = EV_NONE;
    case (ph)
      PH_EMPTY: begin
        if (req.cid != '0) begin
          ph_next  = PH_WAIT_INSERT;
          cnt_next = cfg.count_preset;
        end else begin
          seen_set = 1'b1;
        end
      end
      PH_WAIT_INSERT: begin
        if (req.cid != '0) begin
          cnt_next = up_sat;
          if (up_commit) begin
            if (req.insert_ok) begin
              ph_next   = PH_WORKING;
              inst_next = cid_wide[TYPE_BITS-1:0];
              ev        = EV_INSERTED;
            end else begin
              ph_next = PH_EMPTY;
              ev      = EV_REFUSED;
            end
          end
        end else begin
          cnt_next = down_val;
          if (down_abandon) begin
            ph_next = PH_EMPTY;
          end
        end
      end
      PH_WORKING: begin
        if (req.cid != inst8) begin
          ph_next  = PH_WAIT_REMOVE;
          cnt_next = cfg.count_preset;
        end else begin
          seen_set = 1'b1;
        end
      end
      PH_WAIT_REMOVE: begin
        if (req.cid != inst8) begin
          cnt_next = up_sat;
          if (up_commit) begin
            ph_next   = PH_EMPTY;
            inst_next = '0;
            ev        = EV_REMOVED;
          end
        end else begin
          cnt_next = down_val;
          if (down_abandon) begin
            ph_next = PH_WORKING;
          end
        end
      end
      default: begin
        ph_next = ph;
      end
    endcase
    if (!req.in_range) begin
      ev = EV_NONE;
    end

    // Settled marks after this poll, and the one-shot sweep check.
    seen_next = seen;
    if (req.in_range && seen_set) begin
      seen_next[idx] = 1'b1;
    end
    pulse     = req.end_of_sweep && !announced && (&seen_next);
    held_wide = 16'(inst_next);
  end

  // Slot state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        phase[i] <= PH_EMPTY;
        count[i] <= '0;
        inst[i]  <= '0;
      end
      seen      <= '0;
      announced <= 1'b0;
    end else if (req_take) begin
      if (req.in_range) begin
        phase[idx] <= ph_next;
        count[idx] <= cnt_next;
        inst[idx]  <= inst_next;
      end
      seen <= seen_next;
      if (pulse) begin
        announced <= 1'b1;
      end
    end
  end

  // Result register; refills when a request waits and it is empty or unstalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      slot_id     <= req.slot;
      slot_status <= req.in_range ? ph_next : PH_EMPTY;
      event_code  <= ev;
      held_type   <= req.in_range ? held_wide[CARD_W-1:0] : '0;
      all_settled <= pulse;
    end
  end

  `SCPD_NEVER(a_pulse_once, req_take && announced && pulse, "settled pulse fired twice")
  `SCPD_ASSERT(a_removed_empty, out_valid && (event_code == EV_REMOVED) |-> (held_type == '0) && (slot_status == PH_EMPTY), "removal left a type or phase behind")
  `SCPD_ASSERT(a_inserted_working, out_valid && (event_code == EV_INSERTED) |-> (slot_status == PH_WORKING), "insertion did not reach the working phase")

endmodule

@@ rtl/slot_card_presence_debouncer.sv @@
// Channel   Handshake             Payload
// in        in_valid / in_stall   slot_index, card_type, insert_ok, end_of_sweep
// out       out_valid / out_stall slot_id, slot_status, event_code, held_type, all_settled
// cfg       cfg_we                cfg_index, cfg_data
//
// One request is taken per cycle while one is queued and the result register can take it;
// each poll reads its slot and writes an in-range slot's update back when the request is taken.
// Reset empties every slot, clears settled marks and loads preset 4 and confirm level 7.
// A two-entry queue sits between the classifier and the slot engine; in_stall is its full flag.
// The result register takes a new request when one is queued and out_valid or out_stall is low.
module slot_card_presence_debouncer #(
  parameter int SLOT_COUNT = 7,
  parameter int TYPE_BITS  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [scpd_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [scpd_pkg::SLOT_W-1:0] slot_index,
  input  logic [scpd_pkg::CARD_W-1:0] card_type,
  input  logic                        insert_ok,
  input  logic                        end_of_sweep,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [scpd_pkg::SLOT_W-1:0] slot_id,
  output logic [1:0]                  slot_status,
  output logic [1:0]                  event_code,
  output logic [scpd_pkg::CARD_W-1:0] held_type,
  output logic                        all_settled
);
  import scpd_pkg::*;

  cfg_t cfg;
  req_t front_req;
  req_t back_req;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic q_push;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_preset  <= PRESET_RESET;
      cfg.confirm_level <= CONFIRM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_PRESET:  cfg.count_preset  <= cfg_data;
        CFG_IDX_CONFIRM: cfg.confirm_level <= cfg_data;
        default:         cfg.count_preset  <= cfg.count_preset;
      endcase
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  scpd_front #(
    .SLOT_COUNT (SLOT_COUNT),
    .TYPE_BITS  (TYPE_BITS)
  ) u_front (
    .slot_index   (slot_index),
    .card_type    (card_type),
    .insert_ok    (insert_ok),
    .end_of_sweep (end_of_sweep),
    .req          (front_req)
  );

  scpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_req (front_req),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_req  (back_req)
  );

  scpd_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .TYPE_BITS  (TYPE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req_avail   (!q_empty),
    .req         (back_req),
    .req_take    (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot_id     (slot_id),
    .slot_status (slot_status),
    .event_code  (event_code),
    .held_type   (held_type),
    .all_settled (all_settled)
  );

endmodule

@@ tb/testbench.sv @@
module testbench;
  import scpd_pkg::*;

  localparam int SLOTS       = 7;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_POLLS = 350;

  // One poll request as offered on the input channel.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CARD_W-1:0] card;
    logic              ok;
    logic              eos;
  } poll_req_t;

  // One slot report as seen on the output channel.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    phase_t            status;
    event_t            ev;
    logic [CARD_W-1:0] held;
    logic              settled;
  } poll_result_t;

  // A row of the directed plan: either a configuration change or a poll.
  typedef struct {
    bit           is_cfg;
    logic [3:0]   preset;
    logic [3:0]   confirm;
    poll_req_t    req;
    bit           typed;
    poll_result_t want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [SLOT_W-1:0] slot_index = '0;
  logic [CARD_W-1:0] card_type = '0;
  logic              insert_ok = 1'b0;
  logic              end_of_sweep = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SLOT_W-1:0] slot_id;
  logic [1:0]        slot_status;
  logic [1:0]        event_code;
  logic [CARD_W-1:0] held_type;
  logic              all_settled;

  // Mirror of the per-slot debounce state and the live configuration.
  phase_t            mirror_phase [SLOTS];
  logic [CNT_W-1:0]  mirror_count [SLOTS];
  logic [CARD_W-1:0] mirror_type [SLOTS];
  bit [SLOTS-1:0]    mirror_settled = '0;
  bit                pulse_done = 1'b0;
  logic [CFG_W-1:0]  cfg_preset = PRESET_RESET;
  logic [CFG_W-1:0]  cfg_confirm = CONFIRM_RESET;

  poll_result_t      expected_reports [$];
  plan_row_t         test_plan [$];
  logic [CARD_W-1:0] bay_card [8];
  int                sweep_pos = 0;
  bit                idle_on = 1'b0;
  bit                hold_request = 1'b0;
  int                mismatch_count = 0;
  int                cycle_count = 0;

  slot_card_presence_debouncer #(
    .SLOT_COUNT(SLOTS),
    .TYPE_BITS (CARD_W)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .slot_index  (slot_index),
    .card_type   (card_type),
    .insert_ok   (insert_ok),
    .end_of_sweep(end_of_sweep),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot_id     (slot_id),
    .slot_status (slot_status),
    .event_code  (event_code),
    .held_type   (held_type),
    .all_settled (all_settled)
  );

  always #6 clk = ~clk;

  // Free-running cycle count, which also bounds the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("slot_card_presence_debouncer verification failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  function automatic int idle_cycles();
    return idle_on ? $urandom_range(0, 6) : 0;
  endfunction

  // Count toward a commit; the commit test sees the value before saturation.
  function automatic bit tally_up(input int s);
    logic [CNT_W:0] next;
    next = {1'b0, mirror_count[s]} + 1'b1;
    mirror_count[s] = (next > {1'b0, CNT_MAX}) ? CNT_MAX : next[CNT_W-1:0];
    return next > {1'b0, cfg_confirm};
  endfunction

  // Count toward abandoning; a counter at zero or one gives up the change.
  function automatic bit tally_down(input int s);
    logic [CNT_W-1:0] prior;
    prior = mirror_count[s];
    mirror_count[s] = (prior == '0) ? '0 : prior - 1'b1;
    return prior <= 1;
  endfunction

  // Apply one poll to the mirrored slot state and return the report it yields.
  function automatic poll_result_t debounce_poll(input poll_req_t r);
    poll_result_t res;
    int s;
    res.slot    = r.slot;
    res.status  = PH_EMPTY;
    res.ev      = EV_NONE;
    res.held    = '0;
    res.settled = 1'b0;
    if (r.slot < SLOTS) begin
      s = r.slot;
      case (mirror_phase[s])
        PH_EMPTY: begin
          if (r.card != '0) begin
            mirror_phase[s] = PH_WAIT_INSERT;
            mirror_count[s] = cfg_preset;
          end else begin
            mirror_settled[s] = 1'b1;
          end
        end
        PH_WAIT_INSERT: begin
          if (r.card != '0) begin
            if (tally_up(s)) begin
              if (r.ok) begin
                mirror_phase[s] = PH_WORKING;
                mirror_type[s]  = r.card;
                res.ev          = EV_INSERTED;
              end else begin
                mirror_phase[s] = PH_EMPTY;
                res.ev          = EV_REFUSED;
              end
            end
          end else if (tally_down(s)) begin
            mirror_phase[s] = PH_EMPTY;
          end
        end
        PH_WORKING: begin
          // Any other reading, a different card type included, starts a removal.
          if (r.card != mirror_type[s]) begin
            mirror_phase[s] = PH_WAIT_REMOVE;
            mirror_count[s] = cfg_preset;
          end else begin
            mirror_settled[s] = 1'b1;
          end
        end
        default: begin
          if (r.card != mirror_type[s]) begin
            if (tally_up(s)) begin
              mirror_type[s]  = '0;
              mirror_phase[s] = PH_EMPTY;
              res.ev          = EV_REMOVED;
            end
          end else if (tally_down(s)) begin
            mirror_phase[s] = PH_WORKING;
          end
        end
      endcase
      res.status = mirror_phase[s];
      res.held   = mirror_type[s];
    end
    // The settled pulse fires once, at the end of the first fully settled sweep.
    if (r.eos && !pulse_done && (&mirror_settled)) begin
      pulse_done  = 1'b1;
      res.settled = 1'b1;
    end
    return res;
  endfunction

  task automatic plan_poll(input logic [SLOT_W-1:0] slot, input logic [CARD_W-1:0] card,
                           input logic ok, input logic eos);
    plan_row_t row;
    row.is_cfg   = 1'b0;
    row.preset   = '0;
    row.confirm  = '0;
    row.req.slot = slot;
    row.req.card = card;
    row.req.ok   = ok;
    row.req.eos  = eos;
    row.typed    = 1'b0;
    row.want     = '0;
    test_plan.push_back(row);
  endtask

  task automatic plan_typed(input logic [SLOT_W-1:0] slot, input logic [CARD_W-1:0] card,
                            input logic ok, input logic eos, input phase_t status,
                            input event_t ev, input logic [CARD_W-1:0] held,
                            input logic settled);
    plan_row_t row;
    plan_poll(slot, card, ok, eos);
    row = test_plan.pop_back();
    row.typed        = 1'b1;
    row.want.slot    = slot;
    row.want.status  = status;
    row.want.ev      = ev;
    row.want.held    = held;
    row.want.settled = settled;
    test_plan.push_back(row);
  endtask

  task automatic plan_config(input logic [3:0] preset, input logic [3:0] confirm);
    plan_row_t row;
    row.is_cfg  = 1'b1;
    row.preset  = preset;
    row.confirm = confirm;
    row.req     = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    test_plan.push_back(row);
  endtask

  // Offer one request after any idle gap and record its expected report once taken.
  task automatic offer_poll(input poll_req_t r, input bit typed, input poll_result_t want);
    int gap;
    poll_result_t got;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    slot_index   <= r.slot;
    card_type    <= r.card;
    insert_ok    <= r.ok;
    end_of_sweep <= r.eos;
    do @(posedge clk); while (in_stall);
    got = debounce_poll(r);
    expected_reports.push_back(typed ? want : got);
  endtask

  // Let the block drain completely, then write both registers.
  task automatic reconfigure(input logic [3:0] preset, input logic [3:0] confirm);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_PRESET;
    cfg_data  <= preset;
    @(posedge clk);
    cfg_index <= CFG_IDX_CONFIRM;
    cfg_data  <= confirm;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cfg_preset  = preset;
    cfg_confirm = confirm;
  endtask

  // Sweeps over the slots with cards that come and go, plus glitches and stray polls.
  task automatic random_phase(input int polls);
    poll_req_t r;
    int pick;
    repeat (polls) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        r.slot = 3'd7;
        r.eos  = 1'($urandom_range(0, 1));
      end else if (pick < 8) begin
        r.slot = 3'($urandom_range(0, SLOTS - 1));
        r.eos  = 1'b0;
      end else begin
        r.slot    = 3'(sweep_pos);
        r.eos     = (sweep_pos == SLOTS - 1);
        sweep_pos = (sweep_pos + 1) % SLOTS;
      end
      if ($urandom_range(0, 99) < 6) begin
        bay_card[r.slot] = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
      end
      r.card = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(0, 255)) : bay_card[r.slot];
      r.ok   = ($urandom_range(0, 9) != 0);
      offer_poll(r, 1'b0, '0);
    end
  endtask

  // Compare every accepted report with the oldest expectation.
  always @(posedge clk) begin : check_reports
    poll_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        flag_mismatch($sformatf("report for slot %0d with no poll pending", slot_id));
      end else begin
        want = expected_reports.pop_front();
        if (slot_id !== want.slot)
          flag_mismatch($sformatf("slot_id %0d, want %0d", slot_id, want.slot));
        if (slot_status !== want.status)
          flag_mismatch($sformatf("slot %0d status %0d, want %0d",
                                  want.slot, slot_status, want.status));
        if (event_code !== want.ev)
          flag_mismatch($sformatf("slot %0d event %0d, want %0d",
                                  want.slot, event_code, want.ev));
        if (held_type !== want.held)
          flag_mismatch($sformatf("slot %0d held type %0h, want %0h",
                                  want.slot, held_type, want.held));
        if (all_settled !== want.settled)
          flag_mismatch($sformatf("slot %0d all_settled %0b, want %0b",
                                  want.slot, all_settled, want.settled));
      end
    end
  end

  // Report sink: random stalls per report, with one long hold-off on request.
  initial begin : report_sink
    int hold;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      hold = idle_cycles();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus: directed plan first, then random sweeps under several settings.
  initial begin : stimulus
    int round;
    for (int i = 0; i < SLOTS; i++) begin
      mirror_phase[i] = PH_EMPTY;
      mirror_count[i] = '0;
      mirror_type[i]  = '0;
    end
    for (int i = 0; i < 8; i++) bay_card[i] = '0;

    // Fresh after reset: a stray slot, then one settled sweep that fires the pulse.
    plan_typed(3'd7, 8'hFF, 1'b1, 1'b1, PH_EMPTY, EV_NONE, 8'h00, 1'b0);
    for (int s = 0; s < SLOTS; s++) begin
      plan_typed(3'(s), 8'h00, 1'(s % 2), 1'(s == SLOTS - 1), PH_EMPTY, EV_NONE, 8'h00,
                 1'(s == SLOTS - 1));
    end
    // The pulse never repeats.
    plan_typed(3'd7, 8'h00, 1'b0, 1'b1, PH_EMPTY, EV_NONE, 8'h00, 1'b0);
    plan_typed(3'd1, 8'h80, 1'b1, 1'b0, PH_WAIT_INSERT, EV_NONE, 8'h00, 1'b0);
    plan_poll(3'd1, 8'h00, 1'b0, 1'b0);
    // Top settings: the saturated counter still commits; refusal, insert, swap, removal.
    plan_config(4'd15, 4'd15);
    plan_poll(3'd2, 8'hFF, 1'b0, 1'b0);
    plan_typed(3'd2, 8'h01, 1'b0, 1'b0, PH_EMPTY, EV_REFUSED, 8'h00, 1'b0);
    plan_poll(3'd3, 8'h5A, 1'b1, 1'b0);
    plan_poll(3'd3, 8'hA5, 1'b1, 1'b0);
    plan_poll(3'd3, 8'hA5, 1'b0, 1'b0);
    plan_poll(3'd3, 8'h3C, 1'b0, 1'b0);
    plan_poll(3'd3, 8'h3C, 1'b1, 1'b0);
    // Bottom settings: abandoned insertion from zero, insert, abandoned removal.
    plan_config(4'd0, 4'd0);
    plan_poll(3'd4, 8'h01, 1'b1, 1'b0);
    plan_poll(3'd4, 8'h00, 1'b1, 1'b0);
    plan_poll(3'd4, 8'h01, 1'b0, 1'b0);
    plan_poll(3'd4, 8'h01, 1'b1, 1'b0);
    plan_poll(3'd4, 8'h02, 1'b0, 1'b0);
    plan_poll(3'd4, 8'h01, 1'b0, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (test_plan[i]) begin
      if (test_plan[i].is_cfg) reconfigure(test_plan[i].preset, test_plan[i].confirm);
      else offer_poll(test_plan[i].req, test_plan[i].typed, test_plan[i].want);
    end

    // Random rounds: the first runs back to back, one includes the long hold-off.
    for (round = 0; round < 4; round++) begin
      if (round == 0) reconfigure(PRESET_RESET, CONFIRM_RESET);
      else reconfigure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      idle_on = (round != 0);
      if (round == 2) hold_request = 1'b1;
      random_phase(PHASE_POLLS);
    end

    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("slot_card_presence_debouncer verification clean");
    end else begin
      $display("slot_card_presence_debouncer verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/scpd_pkg.sv
rtl/scpd_front.sv
rtl/scpd_queue.sv
rtl/scpd_back.sv
rtl/slot_card_presence_debouncer.sv
tb/testbench.sv
